[hdl/f2d_pkg.sv]
// ----------------------------------------------------------------------------
// f2d_pkg
// Shared widths, character codes, stage payload types and the scaling table
// builder for the float32 to decimal text converter.
// ----------------------------------------------------------------------------
package f2d_pkg;

  localparam int FRACTION_DIGITS_DEF = 7;
  localparam int EXPONENT_DIGITS_DEF = 2;

  localparam int VALUE_W   = 32;
  localparam int CHAR_W    = 8;
  localparam int MANT_W    = 24;
  localparam int EXP_W     = 9;
  localparam int P_W       = 9;
  localparam int D_W       = 7;
  localparam int D_MIN     = -45;
  localparam int TBL_N     = 84;
  localparam int IDX_W     = $clog2(TBL_N);
  localparam int COEF_W    = 128;
  localparam int SOFF_W    = 10;
  localparam int SH_W      = 11;
  localparam int PP_W      = MANT_W + 32;
  localparam int HALF_W    = PP_W + 32;
  localparam int PROD_W    = MANT_W + COEF_W;
  localparam int N_W       = 37;
  localparam int MANT10_W  = 30;
  localparam int AD_W      = 6;
  localparam int DIV_S     = N_W + 4;
  localparam longint unsigned DIV10_M = ((64'd1 << DIV_S) + 64'd9) / 64'd10;
  localparam int MUL_W     = 2 * N_W + 1;

  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_QUEST = 8'h3F;
  localparam logic [CHAR_W-1:0] CH_E     = 8'h65;

  typedef struct packed {
    logic [COEF_W-1:0]        coef;
    logic signed [SOFF_W-1:0] soff;
  } scale_ent_t;

  typedef scale_ent_t [TBL_N-1:0] scale_tbl_t;

  typedef struct packed {
    logic                    neg;
    logic                    nf;
    logic                    zero;
    logic [MANT_W-1:0]       m;
    logic signed [EXP_W-1:0] e;
    logic signed [P_W-1:0]   p;
  } dec_t;

  typedef struct packed {
    logic                     neg;
    logic                     nf;
    logic                     zero;
    logic [MANT_W-1:0]        m;
    logic signed [EXP_W-1:0]  e;
    logic signed [D_W-1:0]    d0;
    logic signed [SOFF_W-1:0] soff;
    logic [COEF_W-1:0]        coef;
  } scale_in_t;

  typedef struct packed {
    logic                  neg;
    logic                  nf;
    logic                  zero;
    logic [N_W-1:0]        n;
    logic signed [D_W-1:0] d0;
  } digits_t;

  typedef struct packed {
    logic                neg;
    logic                nf;
    logic [MANT10_W-1:0] mant;
    logic                eneg;
    logic [AD_W-1:0]     ad;
  } run_t;

  function automatic longint unsigned pow10(input int n);
    longint unsigned r;
    r = 64'd1;
    for (int i = 0; i < n; i++) begin
      r = r * 64'd10;
    end
    return r;
  endfunction

  function automatic logic [COEF_W-1:0] pow5(input int n);
    logic [COEF_W-1:0] r;
    r = COEF_W'(1);
    for (int i = 0; i < n; i++) begin
      r = (r << 2) + r;
    end
    return r;
  endfunction

  function automatic int bitlen(input logic [COEF_W-1:0] v);
    int r;
    r = 0;
    for (int i = 0; i < COEF_W; i++) begin
      if (v[i]) begin
        r = i + 1;
      end
    end
    return r;
  endfunction

  // Rounded-up reciprocal 2^t / dv by restoring long division.
  function automatic logic [COEF_W-1:0] ceil_recip(input int t, input logic [COEF_W-1:0] dv);
    logic [COEF_W:0] rem;
    logic [255:0]    q;
    rem = '0;
    q   = '0;
    for (int b = t; b >= 0; b--) begin
      rem = {rem[COEF_W-1:0], (b == t)};
      if (rem >= {1'b0, dv}) begin
        rem  = rem - {1'b0, dv};
        q[b] = 1'b1;
      end
    end
    if (rem != '0) begin
      q = q + 256'd1;
    end
    return q[COEF_W-1:0];
  endfunction

  // Small results multiply by an exact power of five, large ones by a
  // reciprocal of a power of five wide enough that the floor stays exact.
  function automatic scale_tbl_t build_scale_tbl(input int frac_digits);
    scale_tbl_t        tbl;
    logic [COEF_W-1:0] dv;
    int                k;
    int                t;
    for (int i = 0; i < TBL_N; i++) begin
      k = i + D_MIN - (frac_digits + 1);
      if (k <= 0) begin
        tbl[i].coef = pow5(-k);
        tbl[i].soff = SOFF_W'(-k);
      end else begin
        dv          = pow5(k);
        t           = 38 + 2 * bitlen(dv);
        tbl[i].coef = ceil_recip(t, dv);
        tbl[i].soff = SOFF_W'(-(k + t));
      end
    end
    return tbl;
  endfunction

endpackage

[hdl/f2d_stream_if.sv]
// ----------------------------------------------------------------------------
// f2d_stream_if
// Valid/ready channels for float32 values in and characters out.
// ----------------------------------------------------------------------------
interface f2d_in_if import f2d_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] value_bits;

  modport source(output valid, output value_bits, input ready);
  modport sink(input valid, input value_bits, output ready);
endinterface

interface f2d_out_if import f2d_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_code;
  logic              last_char;
  logic              not_finite;

  modport source(output valid, output char_code, output last_char, output not_finite,
                 input ready);
  modport sink(input valid, input char_code, input last_char, input not_finite,
               output ready);
endinterface

[hdl/f2d_front.sv]
// ----------------------------------------------------------------------------
// f2d_front
// Unpacks the float32 fields, estimates the decimal exponent and fetches the
// scaling coefficient for it. Two register stages.
// ----------------------------------------------------------------------------
module f2d_front import f2d_pkg::*; #(
  parameter int FRACTION_DIGITS = FRACTION_DIGITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               adv,
  input  logic               in_valid,
  input  logic [VALUE_W-1:0] value_bits,
  output logic               out_valid,
  output scale_in_t          out
);

  localparam scale_tbl_t SCALE_TBL = build_scale_tbl(FRACTION_DIGITS);

  logic        s1_valid;
  dec_t        s1;
  dec_t        s1_next;
  scale_in_t   s2_next;

  logic [7:0]              expf;
  logic [22:0]             frac;
  logic [4:0]              blen;
  logic signed [EXP_W-1:0] e_v;
  logic signed [26:0]      lp;
  logic signed [D_W-1:0]   d0_v;
  logic signed [D_W:0]     idx_s;
  logic [IDX_W-1:0]        idx;

  always_comb begin
    expf = value_bits[30:23];
    frac = value_bits[22:0];
    e_v  = (expf != '0) ? ($signed({1'b0, expf}) - 9'sd150) : -9'sd149;
    s1_next.neg  = value_bits[31];
    s1_next.nf   = (expf == 8'hFF);
    s1_next.zero = (expf == '0) && (frac == '0);
    s1_next.m    = {(expf != '0), frac};
    s1_next.e    = e_v;
    blen = '0;
    for (int i = 0; i < MANT_W; i++) begin
      if (s1_next.m[i]) begin
        blen = 5'(i + 1);
      end
    end
    s1_next.p = $signed({4'b0, blen}) - 9'sd1 + e_v;
  end

  always_comb begin
    lp    = 27'($signed(s1.p)) * 27'sd78913;
    d0_v  = D_W'(lp >>> 18);
    idx_s = (D_W + 1)'(d0_v) + (D_W + 1)'(-D_MIN);
    if (!idx_s[D_W] && ($unsigned(idx_s) < (D_W + 1)'(TBL_N))) begin
      idx = IDX_W'(idx_s);
    end else begin
      idx = '0;
    end
    s2_next.neg  = s1.neg;
    s2_next.nf   = s1.nf;
    s2_next.zero = s1.zero;
    s2_next.m    = s1.m;
    s2_next.e    = s1.e;
    s2_next.d0   = d0_v;
    s2_next.soff = SCALE_TBL[idx].soff;
    s2_next.coef = SCALE_TBL[idx].coef;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      s1_valid  <= in_valid;
      out_valid <= s1_valid;
    end
    if (adv) begin
      s1  <= s1_next;
      out <= s2_next;
    end
  end

endmodule

[hdl/f2d_scale.sv]
// ----------------------------------------------------------------------------
// f2d_scale
// Multiplies the significand by the scaling coefficient in 32-bit slices,
// sums the partial products in two steps and shifts the product into the
// leading decimal digits. Four register stages.
// ----------------------------------------------------------------------------
module f2d_scale import f2d_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      adv,
  input  logic      in_valid,
  input  scale_in_t in,
  output logic      out_valid,
  output digits_t   out
);

  typedef struct packed {
    logic                  neg;
    logic                  nf;
    logic                  zero;
    logic signed [D_W-1:0] d0;
  } tag_t;

  typedef logic [3:0][PP_W-1:0] pp_t;

  logic                   s3_valid;
  tag_t                   s3_tag;
  pp_t                    s3_pp;
  logic signed [SH_W-1:0] s3_sh;

  logic                   s4_valid;
  tag_t                   s4_tag;
  logic [HALF_W-1:0]      s4_lo;
  logic [HALF_W-1:0]      s4_hi;
  logic signed [SH_W-1:0] s4_sh;

  logic                   s5_valid;
  tag_t                   s5_tag;
  logic [PROD_W-1:0]      s5_prod;
  logic signed [SH_W-1:0] s5_sh;

  pp_t                    pp_next;
  logic [SH_W-1:0]        amt;
  logic [PROD_W-1:0]      shl;
  logic [PROD_W-1:0]      shr;
  digits_t                out_next;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      pp_next[i] = PP_W'(in.m) * PP_W'(in.coef[32 * i +: 32]);
    end
  end

  always_comb begin
    amt = s5_sh[SH_W-1] ? SH_W'(-s5_sh) : SH_W'(s5_sh);
    shl = s5_prod << amt;
    shr = s5_prod >> amt;
    out_next.neg  = s5_tag.neg;
    out_next.nf   = s5_tag.nf;
    out_next.zero = s5_tag.zero;
    out_next.d0   = s5_tag.d0;
    out_next.n    = s5_sh[SH_W-1] ? N_W'(shr) : N_W'(shl);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid  <= 1'b0;
      s4_valid  <= 1'b0;
      s5_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      s3_valid  <= in_valid;
      s4_valid  <= s3_valid;
      s5_valid  <= s4_valid;
      out_valid <= s5_valid;
    end
    if (adv) begin
      s3_tag  <= '{neg: in.neg, nf: in.nf, zero: in.zero, d0: in.d0};
      s3_pp   <= pp_next;
      s3_sh   <= SH_W'($signed(in.e)) + SH_W'($signed(in.soff));
      s4_tag  <= s3_tag;
      s4_lo   <= HALF_W'(s3_pp[0]) + {s3_pp[1], 32'b0};
      s4_hi   <= HALF_W'(s3_pp[2]) + {s3_pp[3], 32'b0};
      s4_sh   <= s3_sh;
      s5_tag  <= s4_tag;
      s5_prod <= PROD_W'(s4_lo) + {s4_hi, 64'b0};
      s5_sh   <= s4_sh;
      out     <= out_next;
    end
  end

endmodule

[hdl/f2d_round.sv]
// ----------------------------------------------------------------------------
// f2d_round
// Settles the decimal exponent, drops the guard digit with round half up,
// renormalizes a carry out of the top digit and forms the exponent magnitude.
// Four register stages.
// ----------------------------------------------------------------------------
module f2d_round import f2d_pkg::*; #(
  parameter int FRACTION_DIGITS = FRACTION_DIGITS_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    adv,
  input  logic    in_valid,
  input  digits_t in,
  output logic    out_valid,
  output run_t    out
);

  localparam logic [N_W-1:0]      HI_LIM      = N_W'(pow10(FRACTION_DIGITS + 2));
  localparam logic [MANT10_W-1:0] MANT_TOP    = MANT10_W'(pow10(FRACTION_DIGITS + 1));
  localparam logic [MANT10_W-1:0] MANT_RENORM = MANT10_W'(pow10(FRACTION_DIGITS));

  typedef struct packed {
    logic neg;
    logic nf;
    logic zero;
  } flag_t;

  logic                  r1_valid;
  flag_t                 r1_flag;
  logic [N_W-1:0]        r1_n;
  logic [MUL_W-1:0]      r1_prod;
  logic                  r1_big;
  logic signed [D_W-1:0] r1_d0;

  logic                  r2_valid;
  flag_t                 r2_flag;
  logic [N_W-1:0]        r2_n9;
  logic signed [D_W-1:0] r2_d;

  logic                  r3_valid;
  flag_t                 r3_flag;
  logic [N_W-1:0]        r3_n9;
  logic [MUL_W-1:0]      r3_prod;
  logic signed [D_W-1:0] r3_d;

  logic [MANT10_W-1:0]   q;
  logic [N_W-1:0]        rem;
  logic [MANT10_W-1:0]   mant_r;
  logic signed [D_W-1:0] d_r;
  run_t                  out_next;

  always_comb begin
    q      = MANT10_W'(r3_prod >> DIV_S);
    rem    = r3_n9 - N_W'(q) * N_W'(10);
    mant_r = q + MANT10_W'(rem > N_W'(4));
    d_r    = r3_d;
    if (mant_r == MANT_TOP) begin
      mant_r = MANT_RENORM;
      d_r    = r3_d + D_W'(1);
    end
    if (r3_flag.zero) begin
      mant_r = '0;
      d_r    = '0;
    end
    out_next.neg  = r3_flag.neg && !r3_flag.zero;
    out_next.nf   = r3_flag.nf;
    out_next.mant = mant_r;
    out_next.eneg = d_r[D_W-1];
    out_next.ad   = d_r[D_W-1] ? AD_W'(-d_r) : AD_W'(d_r);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      r1_valid  <= 1'b0;
      r2_valid  <= 1'b0;
      r3_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      r1_valid  <= in_valid;
      r2_valid  <= r1_valid;
      r3_valid  <= r2_valid;
      out_valid <= r3_valid;
    end
    if (adv) begin
      r1_flag <= '{neg: in.neg, nf: in.nf, zero: in.zero};
      r1_n    <= in.n;
      r1_prod <= MUL_W'(in.n) * MUL_W'(DIV10_M);
      r1_big  <= (in.n >= HI_LIM);
      r1_d0   <= in.d0;
      r2_flag <= r1_flag;
      r2_n9   <= r1_big ? N_W'(r1_prod >> DIV_S) : r1_n;
      r2_d    <= r1_d0 + D_W'(r1_big);
      r3_flag <= r2_flag;
      r3_n9   <= r2_n9;
      r3_prod <= MUL_W'(r2_n9) * MUL_W'(DIV10_M);
      r3_d    <= r2_d;
      out     <= out_next;
    end
  end

endmodule

[hdl/f2d_emit.sv]
// ----------------------------------------------------------------------------
// f2d_emit
// Character serializer. Holds one formatted value and sends its characters
// left to right through an output register, peeling decimal digits from the
// top one per cycle unless stalled. The next value loads as the last character leaves.
// ----------------------------------------------------------------------------
module f2d_emit import f2d_pkg::*; #(
  parameter int FRACTION_DIGITS = FRACTION_DIGITS_DEF,
  parameter int EXPONENT_DIGITS = EXPONENT_DIGITS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  input  run_t         in,
  output logic         in_ready,
  f2d_out_if.source    text
);

  localparam int RUN_LEN   = FRACTION_DIGITS + EXPONENT_DIGITS + 5;
  localparam int POS_W     = $clog2(RUN_LEN);
  localparam int POS_FRAC  = 3;
  localparam int POS_E     = FRACTION_DIGITS + 3;
  localparam int POS_ESIGN = FRACTION_DIGITS + 4;
  localparam int POS_LAST  = RUN_LEN - 1;
  localparam int AX_W      = 10;
  localparam longint unsigned W_X = pow10(FRACTION_DIGITS);
  localparam longint unsigned W_A = pow10(EXPONENT_DIGITS - 1);

  logic                busy;
  logic [POS_W-1:0]    pos;
  logic [MANT10_W-1:0] x;
  logic [AX_W-1:0]     ax;
  logic                neg;
  logic                nf;
  logic                eneg;

  logic                take;
  logic [3:0]          xdig;
  logic [MANT10_W-1:0] xsub;
  logic [MANT10_W-1:0] x_next;
  logic [3:0]          adig;
  logic [AX_W-1:0]     asub;
  logic [AX_W-1:0]     ax_next;
  logic                is_mdig;
  logic                is_adig;
  logic [CHAR_W-1:0]   ch;

  assign take     = !text.valid || text.ready;
  assign in_ready = !busy || (take && (pos == POS_W'(POS_LAST)));

  always_comb begin
    xdig = '0;
    xsub = '0;
    adig = '0;
    asub = '0;
    for (int i = 1; i < 10; i++) begin
      if (x >= MANT10_W'(W_X * i)) begin
        xdig = 4'(i);
        xsub = MANT10_W'(W_X * i);
      end
      if (ax >= AX_W'(W_A * i)) begin
        adig = 4'(i);
        asub = AX_W'(W_A * i);
      end
    end
    x_next  = (x - xsub) * MANT10_W'(10);
    ax_next = (ax - asub) * AX_W'(10);

    is_mdig = (pos == POS_W'(1)) ||
              ((pos >= POS_W'(POS_FRAC)) && (pos < POS_W'(POS_E)));
    is_adig = (pos > POS_W'(POS_ESIGN));

    if (pos == '0) begin
      ch = neg ? CH_MINUS : CH_PLUS;
    end else if (nf) begin
      ch = CH_QUEST;
    end else if (is_mdig) begin
      ch = CH_ZERO | {4'b0, xdig};
    end else if (pos == POS_W'(2)) begin
      ch = CH_DOT;
    end else if (pos == POS_W'(POS_E)) begin
      ch = CH_E;
    end else if (pos == POS_W'(POS_ESIGN)) begin
      ch = eneg ? CH_MINUS : CH_PLUS;
    end else begin
      ch = CH_ZERO | {4'b0, adig};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      pos        <= '0;
      text.valid <= 1'b0;
    end else begin
      if (take) begin
        text.valid <= busy;
      end
      if (take && busy) begin
        pos <= pos + POS_W'(1);
        if (pos == POS_W'(POS_LAST)) begin
          busy <= 1'b0;
        end
      end
      if (in_valid && in_ready) begin
        busy <= 1'b1;
        pos  <= '0;
      end
    end
    if (take && busy) begin
      text.char_code  <= ch;
      text.last_char  <= (pos == POS_W'(POS_LAST));
      text.not_finite <= nf;
      if (is_mdig) begin
        x <= x_next;
      end
      if (is_adig) begin
        ax <= ax_next;
      end
    end
    if (in_valid && in_ready) begin
      x    <= in.mant;
      ax   <= AX_W'(in.ad);
      neg  <= in.neg;
      nf   <= in.nf;
      eneg <= in.eneg;
    end
  end

endmodule

[hdl/float32_to_decimal_sci_text_core.sv]
// ----------------------------------------------------------------------------
// float32_to_decimal_sci_text_core
// Prints float32 bit patterns as fixed-width scientific ASCII text.
// ----------------------------------------------------------------------------
// Each accepted value becomes FRACTION_DIGITS + EXPONENT_DIGITS + 5 characters
// (14 by default) on the text channel, one per cycle while the channel is not
// stalled: sign, leading digit, point, fraction digits, 'e', exponent sign and
// exponent digits, with nine significant digits rounded half up to eight. Zero
// prints as all zeros with plus signs; infinity and NaN print the sign and '?'
// fill with not_finite set. A value passes a ten-stage pipeline (decode and
// table lookup, sliced multiply and shift, exponent fix-up and rounding) before
// the character serializer, which sets the sustained rate: it takes the next
// value only as the last character of the current one leaves, and runs follow
// one another without a gap.
module float32_to_decimal_sci_text_core import f2d_pkg::*; #(
  parameter int FRACTION_DIGITS = FRACTION_DIGITS_DEF,
  parameter int EXPONENT_DIGITS = EXPONENT_DIGITS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  f2d_in_if.sink    value,
  f2d_out_if.source text
);

  logic      adv;
  logic      front_valid;
  scale_in_t front_out;
  logic      scale_valid;
  digits_t   scale_out;
  logic      round_valid;
  run_t      round_out;
  logic      emit_ready;

  assign adv         = !round_valid || emit_ready;
  assign value.ready = adv;

  f2d_front #(
    .FRACTION_DIGITS(FRACTION_DIGITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (value.valid),
    .value_bits(value.value_bits),
    .out_valid (front_valid),
    .out       (front_out)
  );

  f2d_scale u_scale (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .in_valid (front_valid),
    .in       (front_out),
    .out_valid(scale_valid),
    .out      (scale_out)
  );

  f2d_round #(
    .FRACTION_DIGITS(FRACTION_DIGITS)
  ) u_round (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .in_valid (scale_valid),
    .in       (scale_out),
    .out_valid(round_valid),
    .out      (round_out)
  );

  f2d_emit #(
    .FRACTION_DIGITS(FRACTION_DIGITS),
    .EXPONENT_DIGITS(EXPONENT_DIGITS)
  ) u_emit (
    .clk     (clk),
    .rst     (rst),
    .in_valid(round_valid),
    .in      (round_out),
    .in_ready(emit_ready),
    .text    (text)
  );

endmodule

[test/float32_to_decimal_sci_text_core_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// float32_to_decimal_sci_text_core_test
// Self-checking bench for the float32 to scientific text converter. Directed
// values cover zeros, infinities, NaNs, subnormals, the range limits and the
// rounding carry; random patterns of every class follow. Each value accepted
// is expanded into its expected 14 characters, and these are compared in
// order with the characters the block sends, while both channels idle and
// stall at random in the first two phases and never in the last.
// ----------------------------------------------------------------------------
module float32_to_decimal_sci_text_core_test import f2d_pkg::*; ();

  localparam int RUN_CHARS = 14;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int RANDOM_VALUES = 350;

  typedef struct packed {
    logic [CHAR_W-1:0] char_code;
    logic              last_char;
    logic              not_finite;
  } text_char_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  f2d_in_if  value_ch ();
  f2d_out_if text_ch ();

  float32_to_decimal_sci_text_core dut (
    .clk   (clk),
    .rst   (rst),
    .value (value_ch),
    .text  (text_ch)
  );

  logic [VALUE_W-1:0] pending_values[$];
  int                 pending_phase[$];
  text_char_t         expected_chars[$];
  int                 phase = 0;
  int                 failures = 0;
  int                 quiet_cycles = 0;
  int                 send_idle_pct;
  int                 recv_stall_pct;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // floor(m * 2^e / 10^k), saturated to 64 bits.
  function automatic longint unsigned scaled_digits(input logic [23:0] m, input int e,
                                                    input int k);
    logic [511:0] acc;
    acc = 512'(m);
    if (e > 0) acc = acc << e;
    for (int i = 0; i < -k; i++) acc = acc * 512'd10;
    if (e < 0) acc = acc >> (-e);
    for (int i = 0; i < k; i++) acc = acc / 512'd10;
    if (acc[511:64] != '0) return 64'hFFFF_FFFF_FFFF_FFFF;
    return acc[63:0];
  endfunction

  function automatic void predict_text(input logic [VALUE_W-1:0] bits);
    logic              neg;
    logic [7:0]        expf;
    logic [22:0]       frac;
    logic [CHAR_W-1:0] run[RUN_CHARS];
    logic              nf;
    longint unsigned   mant;
    longint unsigned   n;
    int                dexp;
    int                e;
    int                blen;
    int                ad;
    logic [23:0]       m;
    text_char_t        c;
    neg  = bits[31];
    expf = bits[30:23];
    frac = bits[22:0];
    nf   = 1'b0;
    mant = 0;
    dexp = 0;
    if (expf == 8'hFF) begin
      nf = 1'b1;
      run[0] = neg ? CH_MINUS : CH_PLUS;
      for (int i = 1; i < RUN_CHARS; i++) run[i] = CH_QUEST;
    end else begin
      if (expf == 8'h00 && frac == '0) begin
        neg = 1'b0;
      end else begin
        m = (expf != 0) ? {1'b1, frac} : {1'b0, frac};
        e = (expf != 0) ? int'(expf) - 150 : -149;
        blen = 0;
        for (int i = 0; i < 24; i++) if (m[i]) blen = i + 1;
        dexp = (((blen - 1 + e + 160) * 1233) >>> 12) - 48;
        n = 0;
        for (int it = 0; it < 6; it++) begin
          n = scaled_digits(m, e, dexp - 8);
          if (n >= 64'd1000000000) dexp++;
          else if (n < 64'd100000000) dexp--;
          else break;
        end
        mant = n / 10 + (((n % 10) > 4) ? 1 : 0);
        if (mant > 64'd99999999) begin
          mant = mant / 10;
          dexp++;
        end
      end
      run[0] = neg ? CH_MINUS : CH_PLUS;
      for (int i = 9; i >= 3; i--) begin
        run[i] = CH_ZERO + 8'(mant % 10);
        mant = mant / 10;
      end
      run[2]  = CH_DOT;
      run[1]  = CH_ZERO + 8'(mant % 10);
      run[10] = CH_E;
      run[11] = (dexp < 0) ? CH_MINUS : CH_PLUS;
      ad = (dexp < 0) ? -dexp : dexp;
      run[13] = CH_ZERO + 8'(ad % 10);
      run[12] = CH_ZERO + 8'((ad / 10) % 10);
    end
    for (int i = 0; i < RUN_CHARS; i++) begin
      c.char_code  = run[i];
      c.last_char  = (i == RUN_CHARS - 1);
      c.not_finite = nf;
      expected_chars.push_back(c);
    end
  endfunction

  always_comb begin
    case (phase)
      0: begin send_idle_pct = 26; recv_stall_pct = 68; end
      1: begin send_idle_pct = 68; recv_stall_pct = 26; end
      default: begin send_idle_pct = 0; recv_stall_pct = 0; end
    endcase
  end

  always @(posedge clk) begin
    if (rst) begin
      value_ch.valid      <= 1'b0;
      value_ch.value_bits <= '0;
    end else begin
      if (value_ch.valid && value_ch.ready) predict_text(value_ch.value_bits);
      if (!value_ch.valid || value_ch.ready) begin
        if (pending_values.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          phase               <= pending_phase.pop_front();
          value_ch.valid      <= 1'b1;
          value_ch.value_bits <= pending_values.pop_front();
        end else begin
          value_ch.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    text_char_t want;
    if (rst) begin
      text_ch.ready <= 1'b0;
    end else begin
      text_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      if (text_ch.valid && text_ch.ready) begin
        if (expected_chars.size() == 0) begin
          $error("Unexpected character transaction: char_code %h", text_ch.char_code);
          failures++;
        end else begin
          want = expected_chars.pop_front();
          if (text_ch.char_code !== want.char_code) begin
            $error("char_code: expected %h, actual %h", want.char_code, text_ch.char_code);
            failures++;
          end
          if (text_ch.last_char !== want.last_char) begin
            $error("last_char: expected %b, actual %b", want.last_char, text_ch.last_char);
            failures++;
          end
          if (text_ch.not_finite !== want.not_finite) begin
            $error("not_finite: expected %b, actual %b", want.not_finite,
                   text_ch.not_finite);
            failures++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (value_ch.valid && value_ch.ready) || (text_ch.valid && text_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  function automatic logic [VALUE_W-1:0] random_value();
    logic [VALUE_W-1:0] v;
    v = $urandom;
    case ($urandom_range(9))
      0: v[30:23] = 8'h00;
      1: v[30:23] = 8'hFF;
      2: v[22:0] = {1'($urandom_range(1)), 22'h3FFFFF} ^ {23{v[0]}};
      default: ;
    endcase
    return v;
  endfunction

  initial begin
    logic [VALUE_W-1:0] directed[$];
    directed = '{32'h0000_0000, 32'h8000_0000, 32'h7F80_0000, 32'hFF80_0000,
                 32'h7FC0_0001, 32'hFFFF_FFFF, 32'h7F80_0001, 32'h0000_0001,
                 32'h8000_0001, 32'h007F_FFFF, 32'h0080_0000, 32'h7F7F_FFFF,
                 32'hFF7F_FFFF, 32'h3F80_0000, 32'hBF80_0000, 32'h3F7F_FFFF,
                 32'h411F_FFFF, 32'h4CBE_BC20, 32'h4CBE_BC1F, 32'h3DCC_CCCD,
                 32'hAAAA_AAAA, 32'h5555_5555, 32'h4120_0000, 32'h0000_000A};
    foreach (directed[i]) begin
      pending_values.push_back(directed[i]);
      pending_phase.push_back(0);
    end
    for (int i = 0; i < RANDOM_VALUES; i++) begin
      pending_values.push_back(random_value());
      pending_phase.push_back((i * 3) / RANDOM_VALUES);
    end
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    while (pending_values.size() > 0 || value_ch.valid || expected_chars.size() > 0)
      @(posedge clk);
    repeat (40) @(posedge clk);
    if (failures == 0 && expected_chars.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
